// ===== sv/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types, constants, tables and command codes for the softmax
// classifier output block.
// ----------------------------------------------------------------------------
package smc_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int DIV_BITS        = 33;
  localparam int DCNT_W          = 6;

  typedef struct packed {
    logic signed [15:0] logit;
    logic [3:0]         true_label;
    logic               last_logit;
  } in_t;

  typedef struct packed {
    logic [3:0]         class_index;
    logic [15:0]        probability;
    logic signed [15:0] gradient;
    logic               is_final;
    logic [3:0]         predicted_class;
    logic               hit;
    logic [16:0]        sample_loss;
  } out_t;

  typedef logic [3:0] op_t;

  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_LOAD  = 4'd1;
  localparam op_t OP_ERD   = 4'd2;
  localparam op_t OP_EM1   = 4'd3;
  localparam op_t OP_EM2   = 4'd4;
  localparam op_t OP_EWR   = 4'd5;
  localparam op_t OP_DRD   = 4'd6;
  localparam op_t OP_DINIT = 4'd7;
  localparam op_t OP_DSTEP = 4'd8;
  localparam op_t OP_GM1   = 4'd9;
  localparam op_t OP_GM2   = 4'd10;
  localparam op_t OP_EMIT  = 4'd11;

  typedef struct packed {
    logic ld_last;
    logic cls_last;
    logic div_done;
  } status_t;

  function automatic logic [16:0] exp_int(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd24109;
      4'd2:    v = 17'd8869;
      4'd3:    v = 17'd3263;
      4'd4:    v = 17'd1200;
      4'd5:    v = 17'd442;
      4'd6:    v = 17'd162;
      4'd7:    v = 17'd60;
      4'd8:    v = 17'd22;
      4'd9:    v = 17'd8;
      4'd10:   v = 17'd3;
      4'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [16:0] exp_frac(input logic [3:0] i);
    logic [16:0] v;
    case (i)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25665;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/smc_ram.sv =====
// ----------------------------------------------------------------------------
// smc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/smc_ctrl.sv =====
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: load, exp pass per class, then divide, gradient and emit per
// class.
// ----------------------------------------------------------------------------
module smc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  smc_pkg::status_t st,
  output smc_pkg::op_t     op,
  output logic             busy
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ERD   = 4'd1;
  localparam logic [3:0] S_EM1   = 4'd2;
  localparam logic [3:0] S_EM2   = 4'd3;
  localparam logic [3:0] S_EWR   = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DSTEP = 4'd7;
  localparam logic [3:0] S_GM1   = 4'd8;
  localparam logic [3:0] S_GM2   = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = smc_pkg::OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          op = smc_pkg::OP_LOAD;
          if (st.ld_last) state_nxt = S_ERD;
        end
      end
      S_ERD: begin
        op = smc_pkg::OP_ERD;
        state_nxt = S_EM1;
      end
      S_EM1: begin
        op = smc_pkg::OP_EM1;
        state_nxt = S_EM2;
      end
      S_EM2: begin
        op = smc_pkg::OP_EM2;
        state_nxt = S_EWR;
      end
      S_EWR: begin
        op = smc_pkg::OP_EWR;
        state_nxt = st.cls_last ? S_DRD : S_ERD;
      end
      S_DRD: begin
        op = smc_pkg::OP_DRD;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        op = smc_pkg::OP_DINIT;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        op = smc_pkg::OP_DSTEP;
        if (st.div_done) state_nxt = S_GM1;
      end
      S_GM1: begin
        op = smc_pkg::OP_GM1;
        state_nxt = S_GM2;
      end
      S_GM2: begin
        op = smc_pkg::OP_GM2;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        op = smc_pkg::OP_EMIT;
        state_nxt = st.cls_last ? S_IDLE : S_DRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== sv/smc_dp.sv =====
// ----------------------------------------------------------------------------
// smc_dp
// Datapath: logit and exp stores, max tracking, exp tables, serial divider,
// gradient and loss arithmetic, result register.
// ----------------------------------------------------------------------------
module smc_dp #(
  parameter int MAX_CLASSES = smc_pkg::MAX_CLASSES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  smc_pkg::op_t     op,
  input  smc_pkg::in_t     in_data,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  output smc_pkg::status_t st,
  output logic             out_strobe,
  output smc_pkg::out_t    out_data
);

  localparam int IW   = $clog2(MAX_CLASSES);
  localparam int CNTW = $clog2(MAX_CLASSES + 1);
  localparam int SW   = 17 + $clog2(MAX_CLASSES);

  logic [CNTW-1:0]    cnt_r;
  logic signed [15:0] max_r;
  logic [3:0]         label_r;
  logic [IW-1:0]      j_r;
  logic [SW-1:0]      sum_r;
  logic [16:0]        loss_r;
  logic [IW-1:0]      best_r;
  logic [15:0]        best_s_r;
  logic               train_r;

  logic [33:0]        p1_r, p2_r;
  logic [7:0]         frac_r;
  logic [smc_pkg::DIV_BITS-1:0] num_r;
  logic [SW:0]        rem_r;
  logic [15:0]        q_r;
  logic [smc_pkg::DCNT_W-1:0] dcnt_r;
  logic [31:0]        gm_r, sq_r;
  logic [15:0]        s_r;
  logic               neg_r;
  logic [47:0]        gp_r;
  logic               out_strobe_r;
  smc_pkg::out_t      out_data_r;

  logic               load_we;
  logic [15:0]        logit_q;
  logic [16:0]        e_q, e1, e_new;
  logic signed [16:0] diff;
  logic [SW:0]        rem_sh;
  logic               labelled, fin;
  logic [15:0]        mag, pm;
  logic [17:0]        loss_sum;

  function automatic logic [33:0] exp_int_mul(input logic [3:0] k, input logic [3:0] i);
    return 34'(smc_pkg::exp_int(k)) * 34'(smc_pkg::exp_frac(i));
  endfunction

  assign load_we = (op == smc_pkg::OP_LOAD) && (cnt_r < CNTW'(MAX_CLASSES));

  smc_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_logit_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (cnt_r[IW-1:0]),
    .wdata (in_data.logit),
    .raddr (j_r),
    .rdata (logit_q)
  );

  smc_ram #(.WIDTH(17), .DEPTH(MAX_CLASSES)) u_exp_ram (
    .clk   (clk),
    .we    (op == smc_pkg::OP_EWR),
    .waddr (j_r),
    .wdata (e_new),
    .raddr (j_r),
    .rdata (e_q)
  );

  assign diff     = {max_r[15], max_r} - {logit_q[15], logit_q};
  assign e1       = 17'((p1_r + 34'd32768) >> 16);
  assign e_new    = 17'((p2_r + 34'd32768) >> 16);
  assign rem_sh   = {rem_r[SW-1:0], num_r[smc_pkg::DIV_BITS-1]};
  assign labelled = (32'(j_r) == 32'(label_r));
  assign mag      = labelled ? 16'(17'd32768 - 17'(q_r)) : q_r;
  assign loss_sum = {1'b0, loss_r} + 18'((sq_r + 32'd8192) >> 14);
  assign pm       = 16'((gp_r + 48'(1) * 48'h1000_0000) >> 29);
  assign fin      = ((CNTW+1)'(j_r) + (CNTW+1)'(1)) == (CNTW+1)'(cnt_r);

  assign st.ld_last  = in_data.last_logit;
  assign st.cls_last = fin;
  assign st.div_done = (dcnt_r == smc_pkg::DCNT_W'(smc_pkg::DIV_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      max_r        <= 16'sh8000;
      label_r      <= '0;
      j_r          <= '0;
      sum_r        <= '0;
      loss_r       <= '0;
      best_r       <= '0;
      train_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) train_r <= cfg_wdata;
      case (op)
        smc_pkg::OP_LOAD: begin
          if (cnt_r == '0) label_r <= in_data.true_label;
          if (load_we) begin
            cnt_r <= cnt_r + CNTW'(1);
            if (in_data.logit > max_r) max_r <= in_data.logit;
          end
        end
        smc_pkg::OP_EWR: begin
          sum_r <= sum_r + SW'(e_new);
          j_r   <= fin ? '0 : j_r + IW'(1);
        end
        smc_pkg::OP_GM1: begin
          if (j_r == '0 || q_r > best_s_r) best_r <= j_r;
        end
        smc_pkg::OP_GM2: begin
          loss_r <= loss_sum[17] ? 17'h1FFFF : loss_sum[16:0];
        end
        smc_pkg::OP_EMIT: begin
          out_strobe_r <= 1'b1;
          if (fin) begin
            j_r    <= '0;
            cnt_r  <= '0;
            max_r  <= 16'sh8000;
            sum_r  <= '0;
            loss_r <= '0;
          end else begin
            j_r <= j_r + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      smc_pkg::OP_EM1: begin
        p1_r   <= exp_int_mul(diff[15:12], diff[11:8]);
        frac_r <= diff[7:0];
      end
      smc_pkg::OP_EM2: begin
        p2_r <= 34'(e1) * 34'(17'd65536 - {5'd0, frac_r, 4'd0});
      end
      smc_pkg::OP_DINIT: begin
        num_r  <= {1'b0, e_q[16:0], 15'd0} + smc_pkg::DIV_BITS'(sum_r >> 1);
        rem_r  <= '0;
        q_r    <= '0;
        dcnt_r <= '0;
      end
      smc_pkg::OP_DSTEP: begin
        num_r  <= num_r << 1;
        dcnt_r <= dcnt_r + smc_pkg::DCNT_W'(1);
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_r <= rem_sh - {1'b0, sum_r};
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[14:0], 1'b0};
        end
      end
      smc_pkg::OP_GM1: begin
        s_r   <= q_r;
        neg_r <= labelled && (q_r != 16'd32768);
        gm_r  <= 32'(mag) * 32'(q_r);
        sq_r  <= 32'(mag) * 32'(mag);
        if (j_r == '0 || q_r > best_s_r) best_s_r <= q_r;
      end
      smc_pkg::OP_GM2: begin
        gp_r <= 48'(gm_r) * 48'(17'd32768 - 17'(s_r));
      end
      smc_pkg::OP_EMIT: begin
        out_data_r.class_index     <= 4'(j_r);
        out_data_r.probability     <= s_r;
        out_data_r.gradient        <= !train_r ? 16'sd0 :
                                      (neg_r ? -$signed(pm) : $signed(pm));
        out_data_r.is_final        <= fin;
        out_data_r.predicted_class <= fin ? 4'(best_r) : 4'd0;
        out_data_r.hit             <= fin && (32'(best_r) == 32'(label_r));
        out_data_r.sample_loss     <= fin ? loss_r : 17'd0;
      end
      default: begin
      end
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

// ===== sv/softmax_classifier_output_core.sv =====
// ----------------------------------------------------------------------------
// softmax_classifier_output_core
// Softmax, argmax and squared-error gradient over one sample of logits.
//
// Input: one logit beat is taken at each edge with start high and busy low,
// one per cycle while loading. The beat with last_logit set closes the sample
// and raises busy. Logits past MAX_CLASSES are dropped; the label comes from
// the sample's first beat.
// Processing: an exp pass over all classes (table lookup and two
// multiplies per class), then per class the 33-step restoring divider,
// the gradient multiplies and the result register.
// Busy falls in the same cycle that carries the final result.
// Output: one beat per class in class order, each on out_data for a single
// cycle with out_strobe high; the receiver cannot stall. is_final marks the
// last beat, which also carries the argmax, hit and loss.
// Config: cfg_we with cfg_wdata sets train_enable; write only when idle.
// Reset: clears counts, max, sums and train_enable; stores need no clearing.
// ----------------------------------------------------------------------------
module softmax_classifier_output_core #(
  parameter int MAX_CLASSES = smc_pkg::MAX_CLASSES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  smc_pkg::in_t  in_data,
  output logic          out_strobe,
  output smc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  smc_pkg::op_t     op;
  smc_pkg::status_t st;

  smc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy)
  );

  smc_dp #(.MAX_CLASSES(MAX_CLASSES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .in_data    (in_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .st         (st),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.is_final) |-> busy) else $error("result beat while idle");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.is_final) |-> !busy) else $error("busy on final beat");

  a_load_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.last_logit) |=> !busy) else $error("busy mid-sample");

endmodule
